// File: hw/rtl/waes_pkg.sv
// Package for the weekly alarm earliest scheduler.
// Holds the action and status codes, time constants, the queued item type and
// the next-match delay function. It has no dependencies.
`default_nettype none

package waes_pkg;

   localparam int unsigned DEF_TABLE_ENTRIES = 16;
   localparam int unsigned QUEUE_DEPTH       = 2;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_ADD   = 2'd2;
   localparam logic [1:0] ACT_QUERY = 2'd3;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_INDEX = 3'd1;
   localparam logic [2:0] STATUS_INVALID   = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_NO_ALARM  = 3'd4;

   localparam logic [16:0] SEC_PER_HOUR   = 17'd3600;
   localparam logic [16:0] SEC_PER_MINUTE = 17'd60;
   localparam logic [19:0] SEC_PER_DAY    = 20'(24 * 60 * 60);
   localparam logic [16:0] LAST_SECOND    = 17'(24 * 60 * 60 - 1);
   localparam logic [2:0]  DAYS_PER_WEEK  = 3'd7;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  entry_index;
      logic        bad_index;
      logic        alarm_ok;
      logic [6:0]  alarm_days;
      logic [16:0] alarm_second;
      logic [2:0]  weekday;
      logic [16:0] now_sec;
      logic [31:0] epoch_now;
   } waes_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  found_index;
      logic [19:0] delay_seconds;
      logic [32:0] ring_epoch;
   } waes_result_type;

   // Seconds until the next match of a day mask at a second of day, up to
   // seven days ahead; a time already passed today skips to a later matching day, at most a full week on.
   function automatic logic [19:0] waes_delay(input logic [6:0]  days,
                                              input logic [16:0] at_sec,
                                              input logic [2:0]  wd,
                                              input logic [16:0] now_sec);
      logic [3:0]  pos;
      logic        hit;
      logic [2:0]  step;
      logic [19:0] off;
      hit  = 1'b0;
      step = 3'd0;
      for (int i = 0; i < 8; i++) begin
         pos = 4'(wd) + 4'(i);
         if (pos >= 4'(DAYS_PER_WEEK)) begin
            pos = pos - 4'(DAYS_PER_WEEK);
         end
         if (!hit && days[3'(4'd6 - pos)] && !(i == 0 && at_sec < now_sec)) begin
            hit  = 1'b1;
            step = 3'(i);
         end
      end
      off = 20'(step) * SEC_PER_DAY;
      return 20'(at_sec) + off - 20'(now_sec);
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/weekly_alarm_earliest_scheduler.sv
// Weekly alarm table with earliest-alarm query: front end, queue, back end.
// Write, clear and invalid transactions go straight to S_DONE in the back end;
// add runs a first-free search, one slot a cycle; a query does one table read a
// cycle through two pipeline stages, then the finish state and the output register.
// One transaction is executed at a time; the queue and output register decouple.
// Synchronous reset empties the table (valid bits), the queue and the output.
`default_nettype none

module weekly_alarm_earliest_scheduler #(
   parameter int unsigned TABLE_ENTRIES = waes_pkg::DEF_TABLE_ENTRIES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [3:0]  req_entry_index,
   input  wire logic        req_has_name,
   input  wire logic [6:0]  req_alarm_days,
   input  wire logic [16:0] req_alarm_second,
   input  wire logic [2:0]  req_weekday,
   input  wire logic [4:0]  req_hour_now,
   input  wire logic [5:0]  req_minute_now,
   input  wire logic [5:0]  req_second_now,
   input  wire logic [31:0] req_epoch_now,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_found_index,
   output logic [19:0]      rsp_delay_seconds,
   output logic [32:0]      rsp_ring_epoch
);
   import waes_pkg::*;

   logic          queue_full;
   logic          push_valid;
   waes_item_type push_item;
   logic          head_valid;
   waes_item_type head_item;
   logic          pop;

   waes_front #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_entry_index  (req_entry_index),
      .req_has_name     (req_has_name),
      .req_alarm_days   (req_alarm_days),
      .req_alarm_second (req_alarm_second),
      .req_weekday      (req_weekday),
      .req_hour_now     (req_hour_now),
      .req_minute_now   (req_minute_now),
      .req_second_now   (req_second_now),
      .req_epoch_now    (req_epoch_now),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_item        (push_item)
   );

   waes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   waes_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_index   (rsp_found_index),
      .rsp_delay_seconds (rsp_delay_seconds),
      .rsp_ring_epoch    (rsp_ring_epoch)
   );

endmodule

`default_nettype wire

// File: hw/rtl/waes_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module waes_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/waes_front.sv
// Front end: accepts request transactions and classifies them (index check,
// alarm check, clamped seconds, time of day). Depends on waes_pkg.
`default_nettype none

module waes_front #(
   parameter int unsigned TABLE_ENTRIES = waes_pkg::DEF_TABLE_ENTRIES
) (
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_action,
   input  wire logic [3:0]             req_entry_index,
   input  wire logic                   req_has_name,
   input  wire logic [6:0]             req_alarm_days,
   input  wire logic [16:0]            req_alarm_second,
   input  wire logic [2:0]             req_weekday,
   input  wire logic [4:0]             req_hour_now,
   input  wire logic [5:0]             req_minute_now,
   input  wire logic [5:0]             req_second_now,
   input  wire logic [31:0]            req_epoch_now,
   input  wire logic                   queue_full,
   output logic                        push_valid,
   output waes_pkg::waes_item_type     push_item
);
   import waes_pkg::*;

   logic [16:0] now_raw;

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

   always_comb begin
      now_raw = 17'(req_hour_now) * SEC_PER_HOUR
              + 17'(req_minute_now) * SEC_PER_MINUTE
              + 17'(req_second_now);
      push_item.action       = req_action;
      push_item.entry_index  = req_entry_index;
      push_item.bad_index    = 32'(req_entry_index) >= 32'(TABLE_ENTRIES);
      push_item.alarm_ok     = req_has_name && (req_alarm_days != 7'd0);
      push_item.alarm_days   = req_alarm_days;
      push_item.alarm_second = (req_alarm_second > LAST_SECOND) ? LAST_SECOND
                                                                : req_alarm_second;
      push_item.weekday      = (req_weekday == DAYS_PER_WEEK) ? 3'd0 : req_weekday;
      push_item.now_sec      = (now_raw > LAST_SECOND) ? LAST_SECOND : now_raw;
      push_item.epoch_now    = req_epoch_now;
   end

endmodule

`default_nettype wire

// File: hw/rtl/waes_queue.sv
// Short queue between front and back end holding classified transactions.
// Depends on waes_pkg.
`default_nettype none

module waes_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   input  waes_pkg::waes_item_type     push_item,
   output logic                        full,
   output logic                        head_valid,
   output waes_pkg::waes_item_type     head_item,
   input  wire logic                   pop
);
   import waes_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   waes_item_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/waes_back.sv
// Back end: executes table updates, first-free search and the earliest-alarm
// scan, and holds the response register. Depends on waes_pkg and waes_ram.
`default_nettype none

module waes_back #(
   parameter int unsigned TABLE_ENTRIES = waes_pkg::DEF_TABLE_ENTRIES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  waes_pkg::waes_item_type     head_item,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic [3:0]                  rsp_found_index,
   output logic [19:0]                 rsp_delay_seconds,
   output logic [32:0]                 rsp_ring_epoch
);
   import waes_pkg::*;

   localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ADD  = 3'd1;
   localparam logic [2:0] S_QRY  = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     issue_ff, issue_in;
   logic                     any_ff, any_in;
   logic [19:0]              best_delay_ff, best_delay_in;
   logic [IW-1:0]            best_idx_ff, best_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   waes_item_type            cur_ff, cur_in;
   waes_result_type          res_ff, res_in;
   waes_result_type          rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     p1_go_ff, p1_vld_ff, p1_last_ff;
   logic [IW-1:0]            p1_idx_ff;
   logic                     p2_take_ff, p2_last_ff;
   logic [19:0]              p2_delay_ff;
   logic [IW-1:0]            p2_idx_ff;

   logic [IW-1:0]            idx;
   logic                     out_free;
   logic                     ram_we;
   logic [IW-1:0]            ram_waddr;
   logic [23:0]              ram_wdata;
   logic [23:0]              ram_rdata;

   assign idx      = cnt_ff[IW-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   waes_ram #(
      .WIDTH (24),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue_ff),
      .rd_addr (idx),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      issue_in      = issue_ff;
      any_in        = any_ff;
      best_delay_in = best_delay_ff;
      best_idx_in   = best_idx_ff;
      valid_in      = valid_ff;
      cur_in        = cur_ff;
      res_in        = res_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = idx;
      ram_wdata     = {cur_ff.alarm_days, cur_ff.alarm_second};
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cur_in = head_item;
               res_in = '0;
               case (head_item.action)
                  ACT_WRITE: begin
                     if (head_item.bad_index) begin
                        res_in.status = STATUS_BAD_INDEX;
                     end else if (!head_item.alarm_ok) begin
                        res_in.status = STATUS_INVALID;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = IW'(head_item.entry_index);
                        ram_wdata = {head_item.alarm_days, head_item.alarm_second};
                        valid_in[IW'(head_item.entry_index)] = 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  ACT_CLEAR: begin
                     if (head_item.bad_index) begin
                        res_in.status = STATUS_BAD_INDEX;
                     end else begin
                        valid_in[IW'(head_item.entry_index)] = 1'b0;
                     end
                     state_in = S_DONE;
                  end
                  ACT_ADD: begin
                     if (!head_item.alarm_ok) begin
                        res_in.status = STATUS_INVALID;
                        state_in      = S_DONE;
                     end else begin
                        cnt_in   = '0;
                        state_in = S_ADD;
                     end
                  end
                  default: begin
                     cnt_in   = '0;
                     issue_in = 1'b1;
                     any_in   = 1'b0;
                     state_in = S_QRY;
                  end
               endcase
            end
         end
         S_ADD: begin
            if (!valid_ff[idx]) begin
               ram_we             = 1'b1;
               valid_in[idx]      = 1'b1;
               res_in.found_index = 4'(cnt_ff);
               state_in           = S_DONE;
            end else if (cnt_ff == LAST_CNT) begin
               res_in.status = STATUS_FULL;
               state_in      = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_QRY: begin
            if (issue_ff) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LAST_CNT) begin
                  issue_in = 1'b0;
               end
            end
            if (p2_take_ff && (!any_ff || p2_delay_ff < best_delay_ff)) begin
               any_in        = 1'b1;
               best_delay_in = p2_delay_ff;
               best_idx_in   = p2_idx_ff;
            end
            if (p2_last_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            res_in = '0;
            if (any_ff) begin
               res_in.status        = STATUS_OK;
               res_in.found_index   = 4'(best_idx_ff);
               res_in.delay_seconds = best_delay_ff;
               res_in.ring_epoch    = 33'(cur_ff.epoch_now) + 33'(best_delay_ff);
            end else begin
               res_in.status = STATUS_NO_ALARM;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            issue_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         issue_ff     <= 1'b0;
         any_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         p1_go_ff     <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p1_last_ff   <= 1'b0;
         p2_take_ff   <= 1'b0;
         p2_last_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         issue_ff     <= issue_in;
         any_ff       <= any_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_go_ff     <= issue_ff;
         p1_vld_ff    <= valid_ff[idx];
         p1_last_ff   <= cnt_ff == LAST_CNT;
         p2_take_ff   <= p1_go_ff && p1_vld_ff;
         p2_last_ff   <= p1_go_ff && p1_last_ff;
      end
   end

   // scan pipeline: table read, delay, then compare in S_QRY
   always_ff @(posedge clock) begin
      best_delay_ff <= best_delay_in;
      best_idx_ff   <= best_idx_in;
      cur_ff        <= cur_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
      p1_idx_ff     <= idx;
      p2_idx_ff     <= p1_idx_ff;
      p2_delay_ff   <= waes_delay(ram_rdata[23:17], ram_rdata[16:0],
                                  cur_ff.weekday, cur_ff.now_sec);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_found_index   = rsp_ff.found_index;
   assign rsp_delay_seconds = rsp_ff.delay_seconds;
   assign rsp_ring_epoch    = rsp_ff.ring_epoch;

endmodule

`default_nettype wire
